>>> hw/rtl/nnhd_pkg.sv
// Package for the nearest-neighbour half-distance core.
// Holds beat types, the sequencer state type and sizing constants.
// Used by nearest_neighbour_half_distance_core and by tb_top.
package nnhd_pkg;

  localparam int MAX_ATOMS = 64;
  localparam int ADDR_W    = $clog2(MAX_ATOMS);
  localparam int CNT_W     = $clog2(MAX_ATOMS + 1);
  localparam int COORD_W   = 24;
  localparam int RAD_W     = 16;
  localparam int HALF_W    = 24;
  localparam int EXT_W     = 26;
  localparam int SQ_W      = 51;
  localparam int ROOT_STEPS = 25;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic        [RAD_W-1:0]   atom_radius;
    logic                      last_atom;
  } in_beat_t;

  typedef struct packed {
    logic [ADDR_W-1:0] atom_index;
    logic [HALF_W-1:0] half_nearest;
    logic [EXT_W-1:0]  max_extent;
    logic              overflow;
    logic              last_result;
  } out_beat_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_RD_A,
    ST_GET_A,
    ST_RD_B,
    ST_SQUARE,
    ST_SUM,
    ST_ROOT,
    ST_ACC,
    ST_EMIT
  } seq_state_t;

endpackage

>>> hw/rtl/nnhd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module nnhd_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/nearest_neighbour_half_distance_core.sv
// Top level of the nearest-neighbour half-distance core.
// Depends on nnhd_pkg and nnhd_ram.

// The core takes one atom per input beat and stores it in on-chip RAM; loading
// never stalls. The beat flagged last_atom starts the compute phase, during
// which in_stall is high. For each atom a the core walks all atoms b, one pair
// at a time: one RAM read, a registered squaring stage, a registered sum, then
// a shared restoring square-root unit that settles two bits of the squared
// distance per cycle. One result beat per atom leaves in load order; the last
// carries the molecular extent. Atoms beyond 64 are dropped and flag overflow.
module nearest_neighbour_half_distance_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  nnhd_pkg::in_beat_t in_beat,
  output logic               out_valid,
  input  logic               out_stall,
  output nnhd_pkg::out_beat_t out_beat
);
  import nnhd_pkg::*;

  seq_state_t state_r, state_nxt;

  logic [CNT_W-1:0]  cnt_r;
  logic              ovf_r;
  logic [ADDR_W-1:0] a_r, b_r;
  logic [CNT_W-1:0]  last_idx;
  logic              slot_free;
  logic              load_fire;

  // Memory ports.
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [3*COORD_W-1:0] coord_rdata;
  logic [RAD_W-1:0]     rad_rdata;

  // Atom a and pair datapath.
  logic signed [COORD_W-1:0] ax_r, ay_r, az_r;
  logic [RAD_W-1:0]          ra_r, rb_r;
  logic [2*COORD_W-1:0]      sqx_r, sqy_r, sqz_r;
  logic [SQ_W-1:0]           v_r, root_r, bit_r;
  logic [4:0]                step_r;
  logic [EXT_W-1:0]          best_r, ext_r;
  logic                      found_r;

  logic signed [COORD_W-1:0] bx, by, bz;
  logic signed [COORD_W:0]   dx, dy, dz;
  logic [COORD_W-1:0]        mx, my, mz;
  logic [SQ_W-1:0]           trial;
  logic                      take;
  logic [EXT_W-1:0]          pair_root;
  logic [RAD_W+2:0]          rad3;
  logic [EXT_W:0]            pair_ext_wide;
  logic [EXT_W-1:0]          pair_ext;
  logic [HALF_W:0]           half_wide;
  out_beat_t                 out_beat_r;
  logic                      out_valid_r;

  assign last_idx  = cnt_r - CNT_W'(1);
  assign slot_free = !out_valid_r || !out_stall;
  assign load_fire = (state_r == ST_LOAD) && in_valid;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD:   if (in_valid && in_beat.last_atom) state_nxt = ST_RD_A;
      ST_RD_A:   state_nxt = ST_GET_A;
      ST_GET_A:  state_nxt = ST_RD_B;
      ST_RD_B:   state_nxt = ST_SQUARE;
      ST_SQUARE: state_nxt = ST_SUM;
      ST_SUM:    state_nxt = ST_ROOT;
      ST_ROOT:   if (step_r == 5'd0) state_nxt = ST_ACC;
      ST_ACC: begin
        if ({1'b0, b_r} == last_idx) state_nxt = ST_EMIT;
        else state_nxt = ST_RD_B;
      end
      ST_EMIT: begin
        if (slot_free) begin
          if ({1'b0, a_r} == last_idx) state_nxt = ST_LOAD;
          else state_nxt = ST_RD_A;
        end
      end
      default:   state_nxt = ST_LOAD;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_stall  = 1'b1;
    ram_raddr = b_r;
    ram_we    = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_stall = 1'b0;
        ram_we   = in_valid && (cnt_r < CNT_W'(MAX_ATOMS));
      end
      ST_RD_A: ram_raddr = a_r;
      default: ram_raddr = b_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_LOAD;
    else state_r <= state_nxt;
  end

  nnhd_ram #(.DATA_W(3*COORD_W), .DEPTH(MAX_ATOMS)) u_coord_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[ADDR_W-1:0]),
    .wdata ({in_beat.pos_x, in_beat.pos_y, in_beat.pos_z}),
    .raddr (ram_raddr),
    .rdata (coord_rdata)
  );

  nnhd_ram #(.DATA_W(RAD_W), .DEPTH(MAX_ATOMS)) u_radius_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[ADDR_W-1:0]),
    .wdata (in_beat.atom_radius),
    .raddr (ram_raddr),
    .rdata (rad_rdata)
  );

  // Coordinate differences are exact; magnitudes fit 24 bits.
  always_comb begin
    bx = coord_rdata[3*COORD_W-1:2*COORD_W];
    by = coord_rdata[2*COORD_W-1:COORD_W];
    bz = coord_rdata[COORD_W-1:0];
    dx = {ax_r[COORD_W-1], ax_r} - {bx[COORD_W-1], bx};
    dy = {ay_r[COORD_W-1], ay_r} - {by[COORD_W-1], by};
    dz = {az_r[COORD_W-1], az_r} - {bz[COORD_W-1], bz};
    mx = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
    my = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
    mz = dz[COORD_W] ? COORD_W'(-dz) : dz[COORD_W-1:0];
  end

  // One restoring square-root step: two bits of the radicand per cycle.
  assign trial = root_r + bit_r;
  assign take  = (v_r >= trial);

  // Pair extent: distance plus floor(3 * (ra + rb) / 2), saturated.
  assign pair_root     = root_r[EXT_W-1:0];
  assign rad3          = (RAD_W+3)'(ra_r) + (RAD_W+3)'(rb_r);
  assign pair_ext_wide = (EXT_W+1)'(pair_root) + (EXT_W+1)'(((rad3 << 1) + rad3) >> 1);
  assign pair_ext      = pair_ext_wide[EXT_W] ? {EXT_W{1'b1}} : pair_ext_wide[EXT_W-1:0];
  assign half_wide     = best_r[EXT_W-1:1];

  // Control counters and flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
      a_r   <= '0;
      b_r   <= '0;
      step_r <= '0;
      found_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_fire) begin
        if (cnt_r < CNT_W'(MAX_ATOMS)) cnt_r <= cnt_r + CNT_W'(1);
        else ovf_r <= 1'b1;
        a_r <= '0;
      end
      if (state_r == ST_GET_A) begin
        b_r     <= '0;
        found_r <= 1'b0;
      end
      if (state_r == ST_SUM) step_r <= 5'(ROOT_STEPS - 1);
      if (state_r == ST_ROOT && step_r != 5'd0) step_r <= step_r - 5'd1;
      if (state_r == ST_ACC) begin
        if (b_r != a_r) found_r <= 1'b1;
        b_r <= b_r + ADDR_W'(1);
      end
      if (state_r == ST_EMIT && slot_free) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (state_r == ST_EMIT && slot_free) begin
        if ({1'b0, a_r} == last_idx) begin
          cnt_r <= '0;
          ovf_r <= 1'b0;
        end else begin
          a_r <= a_r + ADDR_W'(1);
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (load_fire && in_beat.last_atom) ext_r <= '0;
    if (state_r == ST_GET_A) begin
      ax_r <= coord_rdata[3*COORD_W-1:2*COORD_W];
      ay_r <= coord_rdata[2*COORD_W-1:COORD_W];
      az_r <= coord_rdata[COORD_W-1:0];
      ra_r <= rad_rdata;
    end
    if (state_r == ST_SQUARE) begin
      sqx_r <= mx * mx;
      sqy_r <= my * my;
      sqz_r <= mz * mz;
      rb_r  <= rad_rdata;
    end
    if (state_r == ST_SUM) begin
      v_r    <= SQ_W'(sqx_r) + SQ_W'(sqy_r) + SQ_W'(sqz_r);
      root_r <= '0;
      bit_r  <= SQ_W'(1) << (2 * (ROOT_STEPS - 1));
    end
    if (state_r == ST_ROOT) begin
      if (take) begin
        v_r    <= v_r - trial;
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (state_r == ST_ACC && b_r != a_r) begin
      // The root is monotonic, so the smallest root is the root of the
      // smallest squared distance.
      if (!found_r || pair_root < best_r) best_r <= pair_root;
      if (pair_ext > ext_r) ext_r <= pair_ext;
    end
    if (state_r == ST_EMIT && slot_free) begin
      out_beat_r.atom_index <= a_r;
      if (!found_r || half_wide[HALF_W]) out_beat_r.half_nearest <= {HALF_W{1'b1}};
      else out_beat_r.half_nearest <= half_wide[HALF_W-1:0];
      out_beat_r.overflow <= ovf_r;
      if ({1'b0, a_r} == last_idx) begin
        out_beat_r.max_extent  <= ext_r;
        out_beat_r.last_result <= 1'b1;
      end else begin
        out_beat_r.max_extent  <= '0;
        out_beat_r.last_result <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

>>> tb/sv/tb_top.sv
// Testbench for nearest_neighbour_half_distance_core: loads molecules of atoms and
// checks every result beat against a behavioral predictor of the core.
// Depends on nnhd_pkg and on the core RTL.
module tb_top;
  import nnhd_pkg::*;

  localparam int PEND_DEPTH = 1024;
  localparam int DIR_DEPTH  = 16;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_beat;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_beat;

  nearest_neighbour_half_distance_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_beat(in_beat),
    .out_valid(out_valid), .out_stall(out_stall), .out_beat(out_beat)
  );

  always #6 clk = ~clk;

  // Predictor state: the atoms of the molecule being loaded.
  longint    atom_x[MAX_ATOMS];
  longint    atom_y[MAX_ATOMS];
  longint    atom_z[MAX_ATOMS];
  longint    atom_r[MAX_ATOMS];
  int        atoms_held;
  bit        dropped_atoms;

  // Expected results, oldest at pend_rd.
  out_beat_t pending_results[PEND_DEPTH];
  int        pend_wr;
  int        pend_rd;
  int        mismatches;
  int        results_seen;
  int        beats_sent;
  bit        quiet;

  // Directed stimulus table.
  in_beat_t  dir_beat[DIR_DEPTH];
  bit        dir_known[DIR_DEPTH];
  int        dir_rows;

  task automatic queue_result(out_beat_t r);
    pending_results[pend_wr % PEND_DEPTH] = r;
    pend_wr++;
  endtask

  task automatic add_row(in_beat_t b, bit known);
    dir_beat[dir_rows]  = b;
    dir_known[dir_rows] = known;
    dir_rows++;
  endtask

  // Integer square root, rounded down.
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned root = 0;
    longint unsigned pw = 64'h4000_0000_0000_0000;
    while (pw > v) pw >>= 2;
    while (pw != 0) begin
      if (v >= root + pw) begin
        v -= root + pw;
        root = (root >> 1) + pw;
      end else begin
        root >>= 1;
      end
      pw >>= 2;
    end
    return root;
  endfunction

  function automatic longint unsigned pair_dist_sq(int a, int b);
    longint dx = atom_x[a] - atom_x[b];
    longint dy = atom_y[a] - atom_y[b];
    longint dz = atom_z[a] - atom_z[b];
    return longint'(dx * dx + dy * dy + dz * dz);
  endfunction

  // Accepts one atom beat. On the last atom the molecule is solved and its
  // results are queued; a row with a typed-in answer replaces the prediction.
  task automatic absorb_atom(in_beat_t b, bit known, out_beat_t want);
    longint unsigned best, d2, gap, ext, widest, half;
    bit              found;
    out_beat_t       r;
    if (atoms_held < MAX_ATOMS) begin
      atom_x[atoms_held] = longint'($signed(b.pos_x));
      atom_y[atoms_held] = longint'($signed(b.pos_y));
      atom_z[atoms_held] = longint'($signed(b.pos_z));
      atom_r[atoms_held] = longint'(b.atom_radius);
      atoms_held++;
    end else begin
      dropped_atoms = 1'b1;
    end
    if (!b.last_atom) return;
    if (known) begin
      queue_result(want);
    end else begin
      widest = 0;
      for (int a = 0; a < atoms_held; a++) begin
        found = 1'b0;
        best = 0;
        for (int k = 0; k < atoms_held; k++) begin
          if (k == a) continue;
          d2 = pair_dist_sq(a, k);
          if (!found || d2 < best) best = d2;
          found = 1'b1;
          gap = floor_sqrt(d2);
          ext = gap + (3 * (atom_r[a] + atom_r[k])) / 2;
          if (ext > 64'h3FF_FFFF) ext = 64'h3FF_FFFF;
          if (ext > widest) widest = ext;
        end
        half = found ? (floor_sqrt(best) >> 1) : 64'hFF_FFFF;
        if (half > 64'hFF_FFFF) half = 64'hFF_FFFF;
        r.atom_index   = a[ADDR_W-1:0];
        r.half_nearest = half[HALF_W-1:0];
        r.max_extent   = (a == atoms_held - 1) ? widest[EXT_W-1:0] : '0;
        r.overflow     = dropped_atoms;
        r.last_result  = (a == atoms_held - 1);
        queue_result(r);
      end
    end
    atoms_held = 0;
    dropped_atoms = 1'b0;
  endtask

  function automatic in_beat_t atom(int x, int y, int z, int rad, bit last);
    in_beat_t b;
    b.pos_x = x[COORD_W-1:0];
    b.pos_y = y[COORD_W-1:0];
    b.pos_z = z[COORD_W-1:0];
    b.atom_radius = rad[RAD_W-1:0];
    b.last_atom = last;
    return b;
  endfunction

  // Offers one beat from a falling edge and holds it until accepted. An
  // optional idle burst lowers valid first; valid is otherwise left high.
  task automatic send_atom(in_beat_t b, bit known, out_beat_t want);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    do @(posedge clk); while (in_stall);
    absorb_atom(b, known, want);
    beats_sent++;
    @(negedge clk);
  endtask

  // Random atom: spread over the whole range, or a tight cluster around the
  // given centre when cluster is nonzero, so that distances are small.
  function automatic in_beat_t random_atom(bit last, int cluster);
    in_beat_t b;
    b.pos_x = COORD_W'($urandom);
    b.pos_y = COORD_W'($urandom);
    b.pos_z = COORD_W'($urandom);
    if (cluster != 0) begin
      b.pos_x = COORD_W'(cluster + $urandom_range(0, 8191) - 4096);
      b.pos_y = COORD_W'($urandom_range(0, 8191) - 4096);
      b.pos_z = COORD_W'(-cluster + $urandom_range(0, 8191) - 4096);
    end
    b.atom_radius = RAD_W'($urandom_range(0, 65535));
    b.last_atom = last;
    return b;
  endfunction

  // Stimulus.
  initial begin
    out_beat_t lone_max;
    out_beat_t none;
    in_beat_t  prev;
    int        size, cluster, molecule;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_beat = '0;
    atoms_held = 0;
    dropped_atoms = 1'b0;
    pend_wr = 0;
    pend_rd = 0;
    dir_rows = 0;
    mismatches = 0;
    results_seen = 0;
    beats_sent = 0;
    quiet = 1'b0;
    none = '0;
    lone_max = '{atom_index: '0, half_nearest: 24'hFF_FFFF, max_extent: '0,
                 overflow: 1'b0, last_result: 1'b1};

    // Directed rows. A lone atom has a saturated half distance and no extent.
    add_row(atom(8388607, 8388607, 8388607, 65535, 1), 1);
    add_row(atom(-8388608, -8388608, -8388608, 0, 1), 1);
    // Two atoms at the same spot: nearest distance is zero.
    add_row(atom(0, 0, 0, 0, 0), 0);
    add_row(atom(0, 0, 0, 0, 1), 0);
    // Opposite corners with full radii: the largest extent there is.
    add_row(atom(8388607, 8388607, 8388607, 65535, 0), 0);
    add_row(atom(-8388608, -8388608, -8388608, 65535, 1), 0);
    // A tie: the middle atom is equally near to both neighbors.
    add_row(atom(0, 0, 0, 4096, 0), 0);
    add_row(atom(4096, 0, 0, 4096, 0), 0);
    add_row(atom(-4096, 0, 0, 4096, 1), 0);
    // Separation along each remaining axis, mixed odd and even radii for the rounding.
    add_row(atom(0, 1, 0, 1, 0), 0);
    add_row(atom(0, -8388608, 0, 3, 0), 0);
    add_row(atom(0, 0, 8388607, 32768, 0), 0);
    add_row(atom(0, 0, -1, 21845, 1), 0);

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < dir_rows; i++)
      send_atom(dir_beat[i], dir_known[i], dir_known[i] ? lone_max : none);

    // Random molecules: mostly small, one full molecule and one that runs
    // past capacity so atoms are dropped.
    molecule = 0;
    while (beats_sent < 450) begin
      if (molecule == 5) size = MAX_ATOMS;
      else if (molecule == 14) size = MAX_ATOMS + 6;
      else size = $urandom_range(1, 6);
      cluster = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 65535) - 32768 : 0;
      for (int i = 0; i < size; i++) begin
        if (beats_sent >= 380) quiet = 1'b1;
        if (i > 0 && $urandom_range(0, 9) == 0) begin
          prev.last_atom = (i == size - 1);
          send_atom(prev, 1'b0, none);
        end else begin
          prev = random_atom(i == size - 1, cluster);
          send_atom(prev, 1'b0, none);
        end
      end
      molecule++;
    end
    in_valid <= 1'b0;

    wait (pend_rd == pend_wr);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Receiver: random stall bursts, one long hold once results are flowing so
  // the core backs up into its input, and no stalls near the end.
  initial begin
    bit held;
    held = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= 20) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (400) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Result checker: every accepted beat is matched against the oldest
  // prediction, field by field.
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pend_rd == pend_wr) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", out_beat);
      end else begin
        want = pending_results[pend_rd % PEND_DEPTH];
        pend_rd++;
        if (want.atom_index !== out_beat.atom_index ||
            want.half_nearest !== out_beat.half_nearest ||
            want.max_extent !== out_beat.max_extent ||
            want.overflow !== out_beat.overflow ||
            want.last_result !== out_beat.last_result) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, out_beat);
        end
      end
    end
  end

  // Watchdog.
  initial begin
    #(12 * 3000000);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
